// ===== rtl/core/nppc_pkg.sv =====
`timescale 1ns / 1ps

package nppc_pkg;

    // Sizes
    localparam int PALETTE_SIZE = 6;
    localparam int MAX_LANES    = 8;
    localparam int LANE_IDX_W   = 3;
    localparam int COUNT_W      = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int COLOR_W      = 24;
    localparam int BYTE_W       = 8;
    localparam int TRIG_W       = 16;
    localparam int COORD_W      = 24;
    localparam int DIST_W       = 48;
    localparam int MID_DEPTH    = 4;
    localparam int OUT_DEPTH    = 8;

    // Register map
    localparam logic [CFG_IDX_W-1:0] REG_COUNT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_BASE = 3'd1;

    // Reset values
    localparam logic [COUNT_W-1:0] COUNT_RESET  = 3'd2;
    localparam logic [COLOR_W-1:0] COLOR0_RESET = 24'h0000FF;

    typedef struct packed {
        logic signed [TRIG_W-1:0] s;
        logic signed [TRIG_W-1:0] c;
    } trig_t;

    // Pixel after the front end: plane coordinates plus value
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [BYTE_W-1:0]         val;
    } front_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0]     hue;
        logic [BYTE_W-1:0]     sat;
        logic [BYTE_W-1:0]     val;
        logic [LANE_IDX_W-1:0] idx;
    } result_t;

    // Candidate in the compare tree
    typedef struct packed {
        logic                  valid;
        logic [LANE_IDX_W-1:0] idx;
        logic [DIST_W-1:0]     dsq;
    } node_t;

    // round(16384 * sin(2 deg * k)), k = 0..45
    function automatic logic [14:0] quarter_sin(input logic [5:0] k);
        logic [14:0] v;
        case (k)
            6'd0:  v = 15'd0;
            6'd1:  v = 15'd572;
            6'd2:  v = 15'd1143;
            6'd3:  v = 15'd1713;
            6'd4:  v = 15'd2280;
            6'd5:  v = 15'd2845;
            6'd6:  v = 15'd3406;
            6'd7:  v = 15'd3964;
            6'd8:  v = 15'd4516;
            6'd9:  v = 15'd5063;
            6'd10: v = 15'd5604;
            6'd11: v = 15'd6138;
            6'd12: v = 15'd6664;
            6'd13: v = 15'd7182;
            6'd14: v = 15'd7692;
            6'd15: v = 15'd8192;
            6'd16: v = 15'd8682;
            6'd17: v = 15'd9162;
            6'd18: v = 15'd9630;
            6'd19: v = 15'd10087;
            6'd20: v = 15'd10531;
            6'd21: v = 15'd10963;
            6'd22: v = 15'd11381;
            6'd23: v = 15'd11786;
            6'd24: v = 15'd12176;
            6'd25: v = 15'd12551;
            6'd26: v = 15'd12911;
            6'd27: v = 15'd13255;
            6'd28: v = 15'd13583;
            6'd29: v = 15'd13894;
            6'd30: v = 15'd14189;
            6'd31: v = 15'd14466;
            6'd32: v = 15'd14726;
            6'd33: v = 15'd14968;
            6'd34: v = 15'd15191;
            6'd35: v = 15'd15396;
            6'd36: v = 15'd15582;
            6'd37: v = 15'd15749;
            6'd38: v = 15'd15897;
            6'd39: v = 15'd16026;
            6'd40: v = 15'd16135;
            6'd41: v = 15'd16225;
            6'd42: v = 15'd16294;
            6'd43: v = 15'd16344;
            6'd44: v = 15'd16374;
            6'd45: v = 15'd16384;
            default: v = 15'd0;
        endcase
        return v;
    endfunction

    // Q14 sin/cos of a hue byte; hue repeats every 180 units
    function automatic trig_t trig_lookup(input logic [BYTE_W-1:0] hue);
        logic [BYTE_W-1:0]        r;
        logic [1:0]               q;
        logic [BYTE_W-1:0]        kk;
        logic [5:0]               k;
        logic signed [TRIG_W-1:0] a;
        logic signed [TRIG_W-1:0] b;
        trig_t                    t;
        r = (hue >= 8'd180) ? (hue - 8'd180) : hue;
        if (r < 8'd45) begin
            q  = 2'd0;
            kk = r;
        end else if (r < 8'd90) begin
            q  = 2'd1;
            kk = r - 8'd45;
        end else if (r < 8'd135) begin
            q  = 2'd2;
            kk = r - 8'd90;
        end else begin
            q  = 2'd3;
            kk = r - 8'd135;
        end
        k = kk[5:0];
        a = signed'({1'b0, quarter_sin(k)});
        b = signed'({1'b0, quarter_sin(6'd45 - k)});
        case (q)
            2'd0: begin t.s = a;  t.c = b;  end
            2'd1: begin t.s = b;  t.c = -a; end
            2'd2: begin t.s = -a; t.c = -b; end
            default: begin t.s = -b; t.c = a; end
        endcase
        return t;
    endfunction

    // Q14 trig times an unsigned byte; result fits 24 bits signed
    function automatic logic signed [COORD_W-1:0] coord_mul(
        input logic signed [TRIG_W-1:0] t,
        input logic [BYTE_W-1:0]        m
    );
        logic signed [COORD_W:0] te;
        logic signed [COORD_W:0] me;
        logic signed [COORD_W:0] p;
        te = (COORD_W+1)'(t);
        me = signed'({17'b0, m});
        p  = te * me;
        return p[COORD_W-1:0];
    endfunction

    // Magnitude of a coordinate difference
    function automatic logic [COORD_W-1:0] abs_diff(input logic signed [COORD_W:0] v);
        logic signed [COORD_W:0] n;
        n = -v;
        return v[COORD_W] ? n[COORD_W-1:0] : v[COORD_W-1:0];
    endfunction

    // Right side wins only when strictly nearer: ties keep the lower index
    function automatic node_t pick(input node_t a, input node_t b);
        if (b.valid && (!a.valid || (b.dsq < a.dsq)))
            return b;
        else
            return a;
    endfunction

endpackage

// ===== rtl/core/nearest_palette_color_hsv_top.sv =====
// Nearest palette color in HSV cone space.
// Path from an accepted push to empty going low: front stage, queue,
// six back stages (difference, square, sum, two compare-tree levels, result register), result queue.
// Throughput: one item per cycle, set by the fully pipelined back-end lanes, while a result-queue slot is free.
// Reset (rst_n, async): queues empty, palette_count = 2, entry 0 white, others black.
`timescale 1ns / 1ps

module nearest_palette_color_hsv_top #(
    parameter int PALETTE_SIZE = nppc_pkg::PALETTE_SIZE
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [nppc_pkg::BYTE_W-1:0]     pixel_hue,
    input  logic [nppc_pkg::BYTE_W-1:0]     pixel_sat,
    input  logic [nppc_pkg::BYTE_W-1:0]     pixel_val,
    output logic                            empty,
    input  logic                            pop,
    output logic [nppc_pkg::BYTE_W-1:0]     out_hue,
    output logic [nppc_pkg::BYTE_W-1:0]     out_sat,
    output logic [nppc_pkg::BYTE_W-1:0]     out_val,
    output logic [nppc_pkg::LANE_IDX_W-1:0] chosen_index,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [nppc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nppc_pkg::COLOR_W-1:0]    cfg_data
);

    import nppc_pkg::*;

    logic [COUNT_W-1:0]        count_eff;
    logic [COLOR_W-1:0]        colors [PALETTE_SIZE];
    logic signed [COORD_W-1:0] pal_x [PALETTE_SIZE];
    logic signed [COORD_W-1:0] pal_y [PALETTE_SIZE];

    logic                      mid_wr;
    logic                      mid_rd;
    logic                      mid_full;
    logic                      mid_empty;
    front_item_t               mid_in;
    front_item_t               mid_out;

    logic                      out_wr;
    logic                      out_full;
    logic                      out_pop;
    result_t                   out_in;
    result_t                   out_head;

    // Configuration registers and palette coordinates
    nppc_cfg #(
        .PALETTE_SIZE (PALETTE_SIZE)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .count_eff (count_eff),
        .colors    (colors),
        .pal_x     (pal_x),
        .pal_y     (pal_y)
    );

    // Front end: pixel to cone coordinates
    nppc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .pixel_hue (pixel_hue),
        .pixel_sat (pixel_sat),
        .pixel_val (pixel_val),
        .mid_full  (mid_full),
        .mid_wr    (mid_wr),
        .mid_data  (mid_in)
    );

    // Queue between front and back
    nppc_fifo #(
        .WIDTH ($bits(front_item_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (mid_wr),
        .wr_data (mid_in),
        .rd      (mid_rd),
        .rd_data (mid_out),
        .empty   (mid_empty),
        .full    (mid_full)
    );

    assign out_pop = pop && !empty;

    // Back end: distances and minimum search
    nppc_back #(
        .PALETTE_SIZE (PALETTE_SIZE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (mid_empty),
        .mid_data  (mid_out),
        .mid_rd    (mid_rd),
        .count_eff (count_eff),
        .colors    (colors),
        .pal_x     (pal_x),
        .pal_y     (pal_y),
        .out_pop   (out_pop),
        .out_wr    (out_wr),
        .out_data  (out_in)
    );

    // Result queue; space is reserved at issue, so it never overflows
    nppc_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (out_wr),
        .wr_data (out_in),
        .rd      (pop),
        .rd_data (out_head),
        .empty   (empty),
        .full    (out_full)
    );

    assign out_hue      = out_head.hue;
    assign out_sat      = out_head.sat;
    assign out_val      = out_head.val;
    assign chosen_index = out_full ? out_head.idx : out_head.idx;

endmodule

// ===== rtl/core/nppc_fifo.sv =====
`timescale 1ns / 1ps

module nppc_fifo #(
    parameter int WIDTH = $bits(nppc_pkg::front_item_t),
    parameter int DEPTH = nppc_pkg::MID_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty,
    output logic             full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr;
    logic             do_rd;

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        cnt_next = cnt_reg + CNT_W'(do_wr) - CNT_W'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== rtl/core/nppc_cfg.sv =====
`timescale 1ns / 1ps

module nppc_cfg #(
    parameter int PALETTE_SIZE = nppc_pkg::PALETTE_SIZE
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [nppc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nppc_pkg::COLOR_W-1:0]       cfg_data,
    output logic [nppc_pkg::COUNT_W-1:0]       count_eff,
    output logic [nppc_pkg::COLOR_W-1:0]       colors [PALETTE_SIZE],
    output logic signed [nppc_pkg::COORD_W-1:0] pal_x [PALETTE_SIZE],
    output logic signed [nppc_pkg::COORD_W-1:0] pal_y [PALETTE_SIZE]
);

    import nppc_pkg::*;

    logic [COUNT_W-1:0]        count_reg, count_next;
    logic [COLOR_W-1:0]        color_reg [PALETTE_SIZE];
    logic [COLOR_W-1:0]        color_next [PALETTE_SIZE];
    logic signed [COORD_W-1:0] pal_x_reg [PALETTE_SIZE];
    logic signed [COORD_W-1:0] pal_y_reg [PALETTE_SIZE];
    trig_t                     pal_trig [PALETTE_SIZE];
    logic                      wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid;

    // Register writes; unknown indexes are dropped
    always_comb
    begin
        count_next = count_reg;
        if (wr && (cfg_index == REG_COUNT))
            count_next = cfg_data[COUNT_W-1:0];
        for (int i = 0; i < PALETTE_SIZE; i++)
        begin
            color_next[i] = color_reg[i];
            if (wr && (cfg_index == (REG_COLOR_BASE + CFG_IDX_W'(i))))
                color_next[i] = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_RESET;
            for (int i = 0; i < PALETTE_SIZE; i++)
                color_reg[i] <= (i == 0) ? COLOR0_RESET : '0;
        end
        else
        begin
            count_reg <= count_next;
            for (int i = 0; i < PALETTE_SIZE; i++)
                color_reg[i] <= color_next[i];
        end
    end

    // Sin/cos of each palette hue
    always_comb
    begin
        for (int i = 0; i < PALETTE_SIZE; i++)
            pal_trig[i] = trig_lookup(color_reg[i][23:16]);
    end

    // Palette cone coordinates, refreshed every cycle from the color registers
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < PALETTE_SIZE; i++)
        begin
            pal_x_reg[i] <= coord_mul(pal_trig[i].c, color_reg[i][15:8]);
            pal_y_reg[i] <= coord_mul(pal_trig[i].s, color_reg[i][15:8]);
        end
    end

    // Count clamped to 1..PALETTE_SIZE
    always_comb
    begin
        if (count_reg == '0)
            count_eff = COUNT_W'(1);
        else if (count_reg > COUNT_W'(PALETTE_SIZE))
            count_eff = COUNT_W'(PALETTE_SIZE);
        else
            count_eff = count_reg;
    end

    assign colors = color_reg;
    assign pal_x  = pal_x_reg;
    assign pal_y  = pal_y_reg;

endmodule

// ===== rtl/core/nppc_front.sv =====
`timescale 1ns / 1ps

module nppc_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [nppc_pkg::BYTE_W-1:0] pixel_hue,
    input  logic [nppc_pkg::BYTE_W-1:0] pixel_sat,
    input  logic [nppc_pkg::BYTE_W-1:0] pixel_val,
    input  logic                        mid_full,
    output logic                        mid_wr,
    output nppc_pkg::front_item_t       mid_data
);

    import nppc_pkg::*;

    logic        vld_reg, vld_next;
    front_item_t item_reg;
    logic        accept;
    trig_t       trig;

    // Stage holds while the queue is full
    assign full     = vld_reg && mid_full;
    assign accept   = push && !full;
    assign mid_wr   = vld_reg && !mid_full;
    assign mid_data = item_reg;
    assign vld_next = accept || (vld_reg && mid_full);
    assign trig     = trig_lookup(pixel_hue);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    // Pixel to cone coordinates
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.x   <= coord_mul(trig.c, pixel_sat);
            item_reg.y   <= coord_mul(trig.s, pixel_sat);
            item_reg.val <= pixel_val;
        end
    end

endmodule

// ===== rtl/core/nppc_back.sv =====
`timescale 1ns / 1ps

module nppc_back #(
    parameter int PALETTE_SIZE = nppc_pkg::PALETTE_SIZE
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                mid_empty,
    input  nppc_pkg::front_item_t               mid_data,
    output logic                                mid_rd,
    input  logic [nppc_pkg::COUNT_W-1:0]        count_eff,
    input  logic [nppc_pkg::COLOR_W-1:0]        colors [PALETTE_SIZE],
    input  logic signed [nppc_pkg::COORD_W-1:0] pal_x [PALETTE_SIZE],
    input  logic signed [nppc_pkg::COORD_W-1:0] pal_y [PALETTE_SIZE],
    input  logic                                out_pop,
    output logic                                out_wr,
    output nppc_pkg::result_t                   out_data
);

    import nppc_pkg::*;

    localparam int NSTAGE = 6;
    localparam int OCC_W  = $clog2(OUT_DEPTH + 1);

    logic [OCC_W-1:0]   occ_reg, occ_next;
    logic [NSTAGE-1:0]  vld_reg;
    logic               issue;

    logic signed [BYTE_W:0] dv [PALETTE_SIZE];
    logic [COORD_W-1:0] adx_reg [PALETTE_SIZE];
    logic [COORD_W-1:0] ady_reg [PALETTE_SIZE];
    logic [BYTE_W-1:0]  adz_reg [PALETTE_SIZE];
    logic [DIST_W-1:0]  sqx_reg [PALETTE_SIZE];
    logic [DIST_W-1:0]  sqy_reg [PALETTE_SIZE];
    logic [15:0]        sqz_reg [PALETTE_SIZE];
    logic [DIST_W-1:0]  dist_reg [PALETTE_SIZE];

    node_t              leaf [MAX_LANES];
    logic [COLOR_W-1:0] color_pad [MAX_LANES];
    node_t              n1_reg [MAX_LANES/2];
    node_t              n2_reg [MAX_LANES/4];
    node_t              win;
    result_t            res_reg;

    // Issue only with a reserved slot in the result queue
    assign issue    = !mid_empty && (occ_reg < OCC_W'(OUT_DEPTH));
    assign mid_rd   = issue;
    assign occ_next = occ_reg + OCC_W'(issue) - OCC_W'(out_pop);
    assign out_wr   = vld_reg[NSTAGE-1];
    assign out_data = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
            vld_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
            vld_reg <= {vld_reg[NSTAGE-2:0], issue};
        end
    end

    // Value differences per entry
    always_comb
    begin
        for (int i = 0; i < PALETTE_SIZE; i++)
            dv[i] = signed'({1'b0, mid_data.val}) - signed'({1'b0, colors[i][7:0]});
    end

    // Per-entry distance lanes: differences, squares, sum
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < PALETTE_SIZE; i++)
        begin
            adx_reg[i] <= abs_diff((COORD_W+1)'(mid_data.x) - (COORD_W+1)'(pal_x[i]));
            ady_reg[i] <= abs_diff((COORD_W+1)'(mid_data.y) - (COORD_W+1)'(pal_y[i]));
            adz_reg[i] <= dv[i][BYTE_W] ? BYTE_W'(-dv[i]) : dv[i][BYTE_W-1:0];

            sqx_reg[i] <= DIST_W'(adx_reg[i]) * DIST_W'(adx_reg[i]);
            sqy_reg[i] <= DIST_W'(ady_reg[i]) * DIST_W'(ady_reg[i]);
            sqz_reg[i] <= 16'(adz_reg[i]) * 16'(adz_reg[i]);

            dist_reg[i] <= sqx_reg[i] + sqy_reg[i] + DIST_W'({sqz_reg[i], 30'b0});
        end
    end

    // Leaves of the compare tree; lanes past the count never win
    for (genvar g = 0; g < MAX_LANES; g++)
    begin : g_leaf
        if (g < PALETTE_SIZE)
        begin : g_used
            assign leaf[g].valid = (g == 0) || (LANE_IDX_W'(g) < count_eff);
            assign leaf[g].idx   = LANE_IDX_W'(g);
            assign leaf[g].dsq   = dist_reg[g];
            assign color_pad[g]  = colors[g];
        end
        else
        begin : g_pad
            assign leaf[g]      = '0;
            assign color_pad[g] = '0;
        end
    end

    assign win = pick(n2_reg[0], n2_reg[1]);

    // Registered minimum tree, lower index on ties
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < MAX_LANES/2; j++)
            n1_reg[j] <= pick(leaf[2*j], leaf[2*j+1]);
        for (int j = 0; j < MAX_LANES/4; j++)
            n2_reg[j] <= pick(n1_reg[2*j], n1_reg[2*j+1]);
        res_reg.hue <= color_pad[win.idx][23:16];
        res_reg.sat <= color_pad[win.idx][15:8];
        res_reg.val <= color_pad[win.idx][7:0];
        res_reg.idx <= win.idx;
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import nppc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 300;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    logic [BYTE_W-1:0]     pixel_hue;
    logic [BYTE_W-1:0]     pixel_sat;
    logic [BYTE_W-1:0]     pixel_val;
    logic                  empty;
    logic                  pop;
    logic [BYTE_W-1:0]     out_hue;
    logic [BYTE_W-1:0]     out_sat;
    logic [BYTE_W-1:0]     out_val;
    logic [LANE_IDX_W-1:0] chosen_index;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [COLOR_W-1:0]    cfg_data;

    // round(16384 * sin(2 deg * k)), k = 0..45
    int sine_q14 [0:45] = '{
        0, 572, 1143, 1713, 2280, 2845, 3406, 3964, 4516, 5063,
        5604, 6138, 6664, 7182, 7692, 8192, 8682, 9162, 9630, 10087,
        10531, 10963, 11381, 11786, 12176, 12551, 12911, 13255, 13583, 13894,
        14189, 14466, 14726, 14968, 15191, 15396, 15582, 15749, 15897, 16026,
        16135, 16225, 16294, 16344, 16374, 16384
    };

    // Shadow copy of the palette registers
    logic [COUNT_W-1:0] pal_count;
    logic [COLOR_W-1:0] pal_color [PALETTE_SIZE];
    logic [COLOR_W-1:0] next_colors [PALETTE_SIZE];

    result_t expected_picks [$];

    int  errors          = 0;
    int  items_sent      = 0;
    int  results_checked = 0;
    int  reg_writes      = 0;
    int  palettes_used   = 0;
    int  input_stalls    = 0;
    int  cycles          = 0;
    int  hold_cycles     = 0;
    logic hold_active    = 1'b0;
    bit  sender_idle     = 1'b1;
    bit  receiver_idle   = 1'b1;

    nearest_palette_color_hsv_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .pixel_hue    (pixel_hue),
        .pixel_sat    (pixel_sat),
        .pixel_val    (pixel_val),
        .empty        (empty),
        .pop          (pop),
        .out_hue      (out_hue),
        .out_sat      (out_sat),
        .out_val      (out_val),
        .chosen_index (chosen_index),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("%0t: timeout with %0d results outstanding", $time,
                         expected_picks.size());
                $display("nearest_palette_color_hsv_top regression: fail");
                $finish;
            end
        end
    end

    // Q14 sin/cos of a hue byte, period 180 units
    function automatic void hue_trig(input logic [BYTE_W-1:0] hue,
                                     output longint s, output longint c);
        int r;
        int k;
        longint a;
        longint b;
        r = hue % 180;
        k = r % 45;
        a = sine_q14[k];
        b = sine_q14[45 - k];
        case (r / 45)
            0: begin s = a;  c = b;  end
            1: begin s = b;  c = -a; end
            2: begin s = -a; c = -b; end
            default: begin s = -b; c = a; end
        endcase
    endfunction

    // Squared cone distance; plane terms scaled by 2^14, value term by 2^15
    function automatic longint cone_dist(input logic [COLOR_W-1:0] a,
                                         input logic [COLOR_W-1:0] b);
        longint sa, ca, sb, cb, dx, dy, dz;
        hue_trig(a[23:16], sa, ca);
        hue_trig(b[23:16], sb, cb);
        dx = ca * longint'(a[15:8]) - cb * longint'(b[15:8]);
        dy = sa * longint'(a[15:8]) - sb * longint'(b[15:8]);
        dz = (longint'(a[7:0]) - longint'(b[7:0])) * 32768;
        return dx * dx + dy * dy + dz * dz;
    endfunction

    // Nearest in-use entry; strictly nearer wins, so ties keep the lower index
    function automatic result_t nearest_entry(input logic [BYTE_W-1:0] h,
                                              input logic [BYTE_W-1:0] s,
                                              input logic [BYTE_W-1:0] v);
        int n;
        int best;
        longint best_d;
        longint d;
        result_t r;
        n = pal_count;
        if (n < 1)
            n = 1;
        if (n > PALETTE_SIZE)
            n = PALETTE_SIZE;
        best = 0;
        best_d = cone_dist(pal_color[0], {h, s, v});
        for (int i = 1; i < n; i++)
        begin
            d = cone_dist(pal_color[i], {h, s, v});
            if (d < best_d)
            begin
                best_d = d;
                best = i;
            end
        end
        r.hue = pal_color[best][23:16];
        r.sat = pal_color[best][15:8];
        r.val = pal_color[best][7:0];
        r.idx = LANE_IDX_W'(best);
        return r;
    endfunction

    // Offer one pixel and wait until it is taken; push stays high on return
    task automatic send_pixel(input logic [BYTE_W-1:0] h, input logic [BYTE_W-1:0] s,
                              input logic [BYTE_W-1:0] v);
        push      <= 1'b1;
        pixel_hue <= h;
        pixel_sat <= s;
        pixel_val <= v;
        @(posedge clk);
        while (full)
        begin
            input_stalls++;
            @(posedge clk);
        end
        expected_picks.insert(expected_picks.size(), nearest_entry(h, s, v));
        items_sent++;
    endtask

    // Random burst of sender idle cycles
    task automatic sender_gap();
        if (sender_idle && $urandom_range(0, 3) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    // Stop sending until every expected result has been popped
    task automatic drain();
        push <= 1'b0;
        do
            @(posedge clk);
        while (expected_picks.size() != 0);
    endtask

    // One register write; cfg_valid stays high on return
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [COLOR_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        reg_writes++;
        if (idx == REG_COUNT)
            pal_count = data[COUNT_W-1:0];
        else if (idx >= REG_COLOR_BASE && idx < REG_COLOR_BASE + PALETTE_SIZE)
            pal_color[idx - REG_COLOR_BASE] = data;
    endtask

    // Load count and all entries from next_colors; count upper bits are noise
    task automatic write_palette(input logic [COUNT_W-1:0] count);
        write_reg(REG_COUNT, {21'($urandom), count});
        for (int i = 0; i < PALETTE_SIZE; i++)
            write_reg(REG_COLOR_BASE + CFG_IDX_W'(i), next_colors[i]);
        cfg_valid <= 1'b0;
        palettes_used++;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Pop side: check each accepted result, then choose next pop value
    initial
    begin : result_checker
        int stall_left;
        result_t want;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                results_checked++;
                if (expected_picks.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual idx %0d",
                             $time, chosen_index);
                    errors++;
                end
                else
                begin
                    want = expected_picks.pop_front();
                    check_field("out_hue", want.hue, out_hue);
                    check_field("out_sat", want.sat, out_sat);
                    check_field("out_val", want.val, out_val);
                    check_field("chosen_index", want.idx, chosen_index);
                end
            end
            if (hold_active)
                pop <= 1'b0;
            else if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else if (receiver_idle && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 11) - 1;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // Long receiver hold-off, counted here
    initial
    begin
        forever
        begin
            wait (hold_cycles != 0);
            @(posedge clk);
            hold_active <= 1'b1;
            repeat (hold_cycles) @(posedge clk);
            hold_active <= 1'b0;
            hold_cycles = 0;
        end
    end

    // Reset palette: white entry 0, black entry 1
    task automatic test_reset_palette();
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd127);
        send_pixel(8'd0, 8'd0, 8'd128);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd90, 8'd255, 8'd0);
    endtask

    // Count zero and overflow, hue quadrant edges, unknown index, ties
    task automatic test_count_and_ties();
        drain();
        next_colors[0] = {8'd0, 8'd255, 8'd255};
        next_colors[1] = {8'd45, 8'd255, 8'd0};
        next_colors[2] = {8'd90, 8'd0, 8'd255};
        next_colors[3] = {8'd135, 8'd255, 8'd128};
        next_colors[4] = {8'd180, 8'd128, 8'd0};
        next_colors[5] = {8'd255, 8'd255, 8'd255};
        // count zero behaves as one
        write_palette(3'd0);
        send_pixel(8'd45, 8'd255, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd0);
        drain();
        // count seven saturates to six; each entry hit exactly
        write_palette(3'd7);
        for (int i = 0; i < PALETTE_SIZE; i++)
            send_pixel(next_colors[i][23:16], next_colors[i][15:8], next_colors[i][7:0]);
        drain();
        // unknown index must be ignored
        write_reg(REG_UNUSED, 24'hFFFFFF);
        cfg_valid <= 1'b0;
        send_pixel(8'd255, 8'd255, 8'd255);
        drain();
        // equal distances and duplicate entries
        next_colors[0] = {8'd0, 8'd200, 8'd50};
        next_colors[1] = {8'd90, 8'd200, 8'd50};
        next_colors[2] = {8'd0, 8'd0, 8'd100};
        next_colors[3] = {8'd0, 8'd0, 8'd110};
        next_colors[4] = {8'd0, 8'd0, 8'd100};
        next_colors[5] = {8'd7, 8'd7, 8'd7};
        write_palette(3'd5);
        send_pixel(8'd45, 8'd200, 8'd50);
        send_pixel(8'd0, 8'd0, 8'd105);
        send_pixel(8'd0, 8'd0, 8'd100);
        // entry past the count is never chosen
        send_pixel(8'd7, 8'd7, 8'd7);
    endtask

    // Random palettes, random and near-entry pixels
    task automatic test_random_palettes();
        logic [BYTE_W-1:0]  h, s, v;
        logic [COLOR_W-1:0] e;
        for (int p = 0; p < 8; p++)
        begin
            drain();
            for (int i = 0; i < PALETTE_SIZE; i++)
            begin
                next_colors[i] = COLOR_W'($urandom);
                if ($urandom_range(0, 3) == 0)
                    next_colors[i][15:8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                if ($urandom_range(0, 3) == 0)
                    next_colors[i][7:0] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                if (i > 0 && $urandom_range(0, 5) == 0)
                    next_colors[i] = next_colors[i - 1];
            end
            write_palette(COUNT_W'($urandom_range(0, 7)));
            if ($urandom_range(0, 2) == 0)
            begin
                write_reg(REG_UNUSED, COLOR_W'($urandom));
                cfg_valid <= 1'b0;
            end
            sender_idle   = (p % 3 != 2);
            receiver_idle = (p % 3 != 2);
            for (int n = 0; n < 65; n++)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    h = BYTE_W'($urandom);
                    s = BYTE_W'($urandom);
                    v = BYTE_W'($urandom);
                end
                else
                begin
                    // near an entry, so the contest between entries is close
                    e = pal_color[$urandom_range(0, PALETTE_SIZE - 1)];
                    h = e[23:16] + BYTE_W'($urandom_range(0, 4)) - 8'd2;
                    s = e[15:8] + BYTE_W'($urandom_range(0, 4)) - 8'd2;
                    v = e[7:0] + BYTE_W'($urandom_range(0, 4)) - 8'd2;
                end
                send_pixel(h, s, v);
                sender_gap();
            end
        end
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
    endtask

    // Receiver holds off while the sender keeps pushing, so the queues fill
    task automatic test_fill_and_stall();
        drain();
        sender_idle = 1'b0;
        hold_cycles = LONG_HOLD;
        for (int n = 0; n < 60; n++)
            send_pixel(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
        drain();
        sender_idle = 1'b1;
    endtask

    // Back-to-back at full rate, no idling on either side
    task automatic test_full_rate();
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        for (int n = 0; n < 100; n++)
            send_pixel(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
    endtask

    // Main sequence
    initial
    begin
        rst_n     = 1'b0;
        push      = 1'b0;
        pop       = 1'b0;
        pixel_hue = '0;
        pixel_sat = '0;
        pixel_val = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        pal_count = COUNT_RESET;
        for (int i = 0; i < PALETTE_SIZE; i++)
            pal_color[i] = '0;
        pal_color[0] = COLOR0_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reset_palette();
        test_count_and_ties();
        test_random_palettes();
        test_fill_and_stall();
        test_full_rate();

        drain();
        repeat (20) @(posedge clk);
        $display("Sent %0d pixels, checked %0d results; %0d register writes over %0d palettes.",
                 items_sent, results_checked, reg_writes, palettes_used);
        $display("Input held off by a full block for %0d cycles; %0d mismatches.",
                 input_stalls, errors);
        if (errors == 0)
            $display("nearest_palette_color_hsv_top regression: pass");
        else
            $display("nearest_palette_color_hsv_top regression: fail");
        $finish;
    end

endmodule
